/* design/lrhc_pkg.sv */
// Package for the light relay hysteresis controller.
// Holds the item and result types, register indexes and reset constants.
// No dependencies; every other design file but lrhc_checker imports it.
`timescale 1ns / 1ps

package lrhc_pkg;

  // Width of a light-sensor converter reading and of both thresholds.
  localparam int SampleBits  = 12;
  localparam int HoldoffBits = 16;
  localparam int RunBits     = 2;
  localparam int CfgDataBits = 16;
  localparam int CfgIdxBits  = 2;

  // Reset values of the configuration registers.
  localparam logic [SampleBits-1:0]  HighThreshRst = SampleBits'(1200);
  localparam logic [SampleBits-1:0]  LowThreshRst  = SampleBits'(275);
  localparam logic [HoldoffBits-1:0] HoldoffRst    = HoldoffBits'(5000);

  // The relay switches once the run of qualifying samples exceeds this.
  localparam logic [RunBits-1:0] RunLimit = RunBits'(2);

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_HIGH_THRESH = 2'd0,
    CFG_LOW_THRESH  = 2'd1,
    CFG_SAVE_HOLD   = 2'd2
  } cfg_idx_e;

  // One poll item.
  typedef struct packed {
    logic                  sample_valid;
    logic [SampleBits-1:0] light_sample;
    logic                  mode_press;
    logic                  light_press;
    logic                  ms_tick;
  } item_t;

  // One result item.
  typedef struct packed {
    logic relay_on;
    logic auto_mode;
    logic save_relay;
    logic save_mode;
    logic display_refresh;
  } result_t;

endpackage : lrhc_pkg

/* design/lrhc_if.sv */
// Channel interfaces of the light relay hysteresis controller.
// A poll item channel and a result channel, each with valid and ready.
// Depends on lrhc_pkg for the sample width.
`timescale 1ns / 1ps

interface lrhc_in_if;
  import lrhc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  sample_valid;
  logic [SampleBits-1:0] light_sample;
  logic                  mode_press;
  logic                  light_press;
  logic                  ms_tick;

  modport source (
    output valid, sample_valid, light_sample, mode_press, light_press, ms_tick,
    input  ready
  );

  modport sink (
    input  valid, sample_valid, light_sample, mode_press, light_press, ms_tick,
    output ready
  );
endinterface : lrhc_in_if

interface lrhc_out_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic auto_mode;
  logic save_relay;
  logic save_mode;
  logic display_refresh;

  modport source (
    output valid, relay_on, auto_mode, save_relay, save_mode, display_refresh,
    input  ready
  );

  modport sink (
    input  valid, relay_on, auto_mode, save_relay, save_mode, display_refresh,
    output ready
  );

  modport monitor (
    input valid, ready, relay_on, auto_mode, save_relay, save_mode, display_refresh
  );
endinterface : lrhc_out_if

/* design/lrhc_in_reg.sv */
// Input register of the light relay hysteresis controller.
// Holds one poll item until the step logic takes it; depends on lrhc_pkg.
`timescale 1ns / 1ps

module lrhc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lrhc_pkg::item_t in_item_i,
  input  logic            step_ready_i,
  output logic            step_fire_o,
  output lrhc_pkg::item_t step_item_o
);
  import lrhc_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The held item moves on whenever the result register can take its result.
  assign step_fire_o = valid_q & step_ready_i;
  assign in_ready_o  = ~valid_q | step_ready_i;
  assign step_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload loads on every input transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule : lrhc_in_reg

/* design/lrhc_step.sv */
// Step logic of the light relay hysteresis controller: configuration
// registers, controller state and the single-pass update. Depends on lrhc_pkg.
`timescale 1ns / 1ps

module lrhc_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrhc_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [lrhc_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  logic                                fire_i,
  input  lrhc_pkg::item_t                     item_i,
  output lrhc_pkg::result_t                   result_o
);
  import lrhc_pkg::*;

  logic [SampleBits-1:0]  high_thresh_q;
  logic [SampleBits-1:0]  low_thresh_q;
  logic [HoldoffBits-1:0] save_hold_q;

  logic                   mode_auto_q,  mode_auto_d;
  logic                   relay_q,      relay_d;
  logic [SampleBits-1:0]  latched_q,    latched_d;
  logic                   pending_q,    pending_d;
  logic [RunBits-1:0]     run_q,        run_d;
  logic [HoldoffBits-1:0] holdoff_q,    holdoff_d;
  logic                   counts;
  result_t                res;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thresh_q <= HighThreshRst;
      low_thresh_q  <= LowThreshRst;
      save_hold_q   <= HoldoffRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HIGH_THRESH: high_thresh_q <= cfg_wdata_i[SampleBits-1:0];
        CFG_LOW_THRESH:  low_thresh_q  <= cfg_wdata_i[SampleBits-1:0];
        CFG_SAVE_HOLD:   save_hold_q   <= cfg_wdata_i[HoldoffBits-1:0];
        default: ;
      endcase
    end
  end

  // One full step: latch the sample, run the mode logic, count the holdoff down.
  always_comb begin
    latched_d   = item_i.sample_valid ? item_i.light_sample : latched_q;
    pending_d   = item_i.sample_valid | pending_q;
    mode_auto_d = mode_auto_q;
    relay_d     = relay_q;
    run_d       = run_q;
    holdoff_d   = holdoff_q;
    counts      = 1'b0;
    res         = '0;

    if (item_i.mode_press) begin
      // A mode press wins over a light press and leaves the sample pending.
      mode_auto_d         = ~mode_auto_q;
      res.save_mode       = 1'b1;
      res.display_refresh = 1'b1;
    end else if (!mode_auto_q) begin
      if (item_i.light_press) begin
        relay_d             = ~relay_q;
        res.display_refresh = 1'b1;
        if (holdoff_q == '0) begin
          res.save_relay = 1'b1;
          holdoff_d      = save_hold_q;
        end
      end
    end else begin
      if (pending_d) begin
        counts = relay_q ? (latched_d > high_thresh_q) : (latched_d < low_thresh_q);
        run_d  = counts ? run_q + RunBits'(1) : '0;
        if (run_d > RunLimit) begin
          relay_d             = ~relay_q;
          res.save_relay      = 1'b1;
          res.display_refresh = 1'b1;
          run_d               = '0;
        end
      end
      pending_d = 1'b0;
    end

    if (item_i.ms_tick && holdoff_d != '0) begin
      holdoff_d = holdoff_d - HoldoffBits'(1);
    end

    res.relay_on  = relay_d;
    res.auto_mode = mode_auto_d;
  end

  assign result_o = res;

  // Controller state advances once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_auto_q <= 1'b1;
      relay_q     <= 1'b0;
      latched_q   <= '0;
      pending_q   <= 1'b0;
      run_q       <= '0;
      holdoff_q   <= HoldoffRst;
    end else if (fire_i) begin
      mode_auto_q <= mode_auto_d;
      relay_q     <= relay_d;
      latched_q   <= latched_d;
      pending_q   <= pending_d;
      run_q       <= run_d;
      holdoff_q   <= holdoff_d;
    end
  end

endmodule : lrhc_step

/* design/lrhc_out_reg.sv */
// Result register of the light relay hysteresis controller.
// Holds one result until the receiver takes it; depends on lrhc_pkg.
`timescale 1ns / 1ps

module lrhc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lrhc_pkg::result_t result_i,
  output logic              load_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrhc_pkg::result_t out_result_o
);
  import lrhc_pkg::*;

  logic    valid_q;
  result_t result_q;

  // A new result may enter when the register is empty or is being drained.
  assign load_ready_o = ~valid_q | out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule : lrhc_out_reg

/* design/light_relay_hysteresis_controller.sv */
// Top level of the light relay hysteresis controller (twilight switch).
// Depends on lrhc_pkg, lrhc_if, lrhc_in_reg, lrhc_step and lrhc_out_reg.
//
// Usage:
//   in_ch carries poll items: an optional light sample, mode and light button
//   press events and a millisecond tick. out_ch carries exactly one result per
//   poll item: relay drive, mode, the two save requests and a display refresh.
//   The cfg_* port writes the high threshold, low threshold and save holdoff;
//   writes to an unused index are dropped.
//   Path: a poll item passes through the input register, then the step logic
//   and the result register, from which its result transfers.
//   Throughput: one item per cycle while out_ch is ready, as the step logic
//   updates its state in a single pass.
//   Reset: automatic mode, relay off, no pending sample, run count zero,
//   holdoff and registers at their defaults; no result is pending.
//   Stall: while out_ch is not ready the result is held, one more item waits
//   in the input register, and in_ch.ready drops until the result transfers.
`timescale 1ns / 1ps

module light_relay_hysteresis_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lrhc_in_if.sink                             in_ch,
  lrhc_out_if.source                          out_ch,
  input  logic                                cfg_we_i,
  input  logic [lrhc_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [lrhc_pkg::CfgDataBits-1:0]    cfg_wdata_i
);
  import lrhc_pkg::*;

  item_t   in_item;
  item_t   step_item;
  logic    step_fire;
  logic    step_ready;
  result_t step_result;
  result_t out_result;

  // Gather the input payload into one item.
  assign in_item.sample_valid = in_ch.sample_valid;
  assign in_item.light_sample = in_ch.light_sample;
  assign in_item.mode_press   = in_ch.mode_press;
  assign in_item.light_press  = in_ch.light_press;
  assign in_item.ms_tick      = in_ch.ms_tick;

  lrhc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .in_item_i    (in_item),
    .step_ready_i (step_ready),
    .step_fire_o  (step_fire),
    .step_item_o  (step_item)
  );

  lrhc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (step_fire),
    .item_i      (step_item),
    .result_o    (step_result)
  );

  lrhc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step_fire),
    .result_i     (step_result),
    .load_ready_o (step_ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_result_o (out_result)
  );

  // Spread the held result onto the output channel.
  assign out_ch.relay_on        = out_result.relay_on;
  assign out_ch.auto_mode       = out_result.auto_mode;
  assign out_ch.save_relay      = out_result.save_relay;
  assign out_ch.save_mode       = out_result.save_mode;
  assign out_ch.display_refresh = out_result.display_refresh;

endmodule : light_relay_hysteresis_controller

/* design/lrhc_checker.sv */
// Port-level checks for the light relay hysteresis controller.
// Watches the result channel only; bound to the top level below.
`timescale 1ns / 1ps

module lrhc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic save_relay_i,
  input logic save_mode_i,
  input logic refresh_i
);

  // Every save request comes from a change that also refreshes the display.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && save_mode_i |-> refresh_i)
    else $error("mode save without display refresh");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && save_relay_i |-> refresh_i)
    else $error("relay save without display refresh");

  // A mode press takes the whole step, so both saves never come together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(save_mode_i && save_relay_i))
    else $error("mode save and relay save in one result");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule : lrhc_checker

bind light_relay_hysteresis_controller lrhc_checker u_lrhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .save_relay_i (out_ch.save_relay),
  .save_mode_i  (out_ch.save_mode),
  .refresh_i    (out_ch.display_refresh)
);
